FILE: rtl/bpit_pkg.sv
// shared constants and the config register type for the barycentric point-in-triangle block
// no dependencies

package bpit_pkg;

  localparam int unsigned OUT_W  = 20;
  localparam int unsigned TOL_W  = 16;
  localparam int unsigned LIM_W  = 16;
  localparam int unsigned CFG_IW = 1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_TOLERANCE = 1'b0,
    CFG_DEG_LIMIT = 1'b1
  } cfg_reg_e;

endpackage

FILE: rtl/barycentric_point_in_triangle.sv
// top level: barycentric weights and inside test of a point against a 2D triangle
// depends on bpit_pkg and bpit_div
//
//   channel  dir  beat contents (lsb first)
//   s_axis   in   ax, ay, bx, by_coord, cx, cy, px, py
//   m_axis   out  weight_u, weight_v, weight_w, inside_res, degenerate, zero pad
//   cfg      in   write enable, register index, data
//
// one beat in and one beat out per cycle unless the output stalls; four front stages,
// OUT_W+4 divider stages (quotient bit steps plus precheck and rounding), output register.
// reset clears valid bits and registers; payload is not reset.
// a stalled output beat freezes the whole pipeline, nothing is dropped.

module barycentric_point_in_triangle import bpit_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned WEIGHT_FRAC = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [8*COORD_WIDTH-1:0] s_axis_tdata,  // ax, ay, bx, by_coord, cx, cy, px, py
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [63:0]              m_axis_tdata,  // u, v, w, inside_res, degenerate, pad
  input  logic                     cfg_we_i,
  input  logic [CFG_IW-1:0]        cfg_idx_i,
  input  logic [TOL_W-1:0]         cfg_data_i
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned EW   = CW + 1;
  localparam int unsigned PW   = 2 * EW;
  localparam int unsigned DENW = PW + 1;
  localparam int unsigned NUW  = DENW + 2;
  localparam int unsigned SH   = WEIGHT_FRAC + 1;
  localparam int unsigned QB   = OUT_W + 2;
  localparam int unsigned DL   = QB + 2;
  localparam logic signed [OUT_W-1:0] U_ONE = (WEIGHT_FRAC >= OUT_W - 1) ?
      OUT_W'((1 << (OUT_W - 1)) - 1) : OUT_W'(1 << WEIGHT_FRAC);

  logic [TOL_W-1:0] tol_q;
  logic [LIM_W-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(7);
      lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TOLERANCE: tol_q <= cfg_data_i;
        CFG_DEG_LIMIT: lim_q <= LIM_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic en;
  assign en            = !(m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = en;

  // stage 1: edge vectors
  logic signed [CW-1:0] ax, ay, bx, by_coord, cx, cy, px, py;
  assign ax       = s_axis_tdata[0*CW +: CW];
  assign ay       = s_axis_tdata[1*CW +: CW];
  assign bx       = s_axis_tdata[2*CW +: CW];
  assign by_coord = s_axis_tdata[3*CW +: CW];
  assign cx       = s_axis_tdata[4*CW +: CW];
  assign cy       = s_axis_tdata[5*CW +: CW];
  assign px       = s_axis_tdata[6*CW +: CW];
  assign py       = s_axis_tdata[7*CW +: CW];

  logic signed [EW-1:0] e0x_q, e0y_q, e1x_q, e1y_q, e2x_q, e2y_q;
  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0x_q <= EW'(bx) - EW'(ax);
      e0y_q <= EW'(by_coord) - EW'(ay);
      e1x_q <= EW'(cx) - EW'(ax);
      e1y_q <= EW'(cy) - EW'(ay);
      e2x_q <= EW'(px) - EW'(ax);
      e2y_q <= EW'(py) - EW'(ay);
    end
  end

  // stage 2: cross product terms
  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= e0x_q * e1y_q;
      pb_q <= e0y_q * e1x_q;
      pc_q <= e2x_q * e1y_q;
      pd_q <= e2y_q * e1x_q;
      pe_q <= e0x_q * e2y_q;
      pf_q <= e0y_q * e2x_q;
    end
  end

  // stage 3: determinant and numerators
  logic signed [DENW-1:0] den_q, nv_q, nw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q <= DENW'(pa_q) - DENW'(pb_q);
      nv_q  <= DENW'(pc_q) - DENW'(pd_q);
      nw_q  <= DENW'(pe_q) - DENW'(pf_q);
    end
  end

  // stage 4: u numerator, magnitudes, signs, degenerate test
  logic signed [NUW-1:0] nu_s, nv_s, nw_s;
  logic [NUW-1:0]        nu_m, nv_m, nw_m;
  logic [DENW-1:0]       dm;
  logic                  deg_d;

  assign nu_s  = NUW'(den_q) - NUW'(nv_q) - NUW'(nw_q);
  assign nv_s  = NUW'(nv_q);
  assign nw_s  = NUW'(nw_q);
  assign nu_m  = nu_s[NUW-1] ? NUW'(-nu_s) : NUW'(nu_s);
  assign nv_m  = nv_s[NUW-1] ? NUW'(-nv_s) : NUW'(nv_s);
  assign nw_m  = nw_s[NUW-1] ? NUW'(-nw_s) : NUW'(nw_s);
  assign dm    = den_q[DENW-1] ? DENW'(-den_q) : DENW'(den_q);
  assign deg_d = (dm[DENW-1:8] == '0) && ((16'(dm[7:0]) * 16'(dm[7:0])) <= 16'(lim_q));

  logic [NUW-1:0]  nu_m_q, nv_m_q, nw_m_q;
  logic [DENW-1:0] dm_q;
  logic            nu_n_q, nv_n_q, nw_n_q, deg4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nu_m_q <= nu_m;
      nv_m_q <= nv_m;
      nw_m_q <= nw_m;
      dm_q   <= dm;
      nu_n_q <= nu_s[NUW-1] ^ den_q[DENW-1];
      nv_n_q <= nv_s[NUW-1] ^ den_q[DENW-1];
      nw_n_q <= nw_s[NUW-1] ^ den_q[DENW-1];
      deg4_q <= deg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // quotient pipelines
  logic signed [OUT_W-1:0] wu, wv, ww;

  bpit_div #(.NW(NUW), .DW(DENW), .SH(SH), .QB(QB)) u_div_u (
    .clk_i, .en_i(en), .num_i(nu_m_q), .den_i(dm_q), .neg_i(nu_n_q), .weight_o(wu)
  );
  bpit_div #(.NW(NUW), .DW(DENW), .SH(SH), .QB(QB)) u_div_v (
    .clk_i, .en_i(en), .num_i(nv_m_q), .den_i(dm_q), .neg_i(nv_n_q), .weight_o(wv)
  );
  bpit_div #(.NW(NUW), .DW(DENW), .SH(SH), .QB(QB)) u_div_w (
    .clk_i, .en_i(en), .num_i(nw_m_q), .den_i(dm_q), .neg_i(nw_n_q), .weight_o(ww)
  );

  logic vd_q   [DL];
  logic degd_q [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= v4_q;
      for (int i = 1; i < DL; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degd_q[0] <= deg4_q;
      for (int i = 1; i < DL; i++) degd_q[i] <= degd_q[i-1];
    end
  end

  // output stage
  logic signed [OUT_W:0]   neg_tol;
  logic signed [OUT_W-1:0] ou, ov, ow;
  logic                    deg_o, ins_o, out_v_q;
  logic [63:0]             out_q;

  assign neg_tol = -(OUT_W+1)'(tol_q);
  assign deg_o   = degd_q[DL-1];
  assign ou      = deg_o ? U_ONE : wu;
  assign ov      = deg_o ? '0 : wv;
  assign ow      = deg_o ? '0 : ww;
  assign ins_o   = !deg_o && ((OUT_W+1)'(wu) >= neg_tol) && ((OUT_W+1)'(wv) >= neg_tol)
                   && ((OUT_W+1)'(ww) >= neg_tol);

  always_ff @(posedge clk_i) begin
    if (en) out_q <= 64'({deg_o, ins_o, ow, ov, ou});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  out_v_q <= 1'b0;
    else if (en)  out_v_q <= vd_q[DL-1];
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_deg_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[61] && m_axis_tdata[60]))
    else $error("degenerate beat flagged inside");

  a_deg_zero_vw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[61]) |-> (m_axis_tdata[59:20] == '0))
    else $error("degenerate beat with nonzero v or w");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vd_q[DL-1]) && $stable(v4_q))
    else $error("pipeline moved during stall");

endmodule

FILE: rtl/bpit_div.sv
// pipelined restoring divider, one quotient bit per stage, rounding and saturation
// depends on bpit_pkg

module bpit_div import bpit_pkg::*; #(
  parameter int unsigned NW = 37,
  parameter int unsigned DW = 35,
  parameter int unsigned SH = 17,
  parameter int unsigned QB = 22
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [NW-1:0]           num_i,
  input  logic [DW-1:0]           den_i,
  input  logic                    neg_i,
  output logic signed [OUT_W-1:0] weight_o
);

  localparam int unsigned RW = NW + SH;
  localparam int unsigned TW = DW + QB;
  localparam int unsigned CW = ((RW > TW) ? RW : TW) + 1;

  logic [CW-1:0] rem_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic          neg_q [QB+1];
  logic          ovf_q [QB+1];
  logic signed [OUT_W-1:0] weight_q;

  logic [CW-1:0] num_ext;
  logic [CW-1:0] lim_ext;

  assign num_ext = CW'({num_i, SH'(0)});
  assign lim_ext = CW'({den_i, QB'(0)});

  // overflow precheck: quotient would need more than QB bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_ext;
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= (num_ext >= lim_ext);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [CW-1:0] trial;
    logic          take;
    assign trial = CW'(den_q[k-1]) << (QB - k);
    assign take  = rem_q[k-1] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? rem_q[k-1] - trial : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | (take ? QB'(1) << (QB - k) : QB'(0));
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  localparam logic [QB:0] MAG_POS = (QB+1)'((1 << (OUT_W-1)) - 1);
  localparam logic [QB:0] MAG_NEG = (QB+1)'(1 << (OUT_W-1));

  logic [QB:0]             mag;
  logic signed [OUT_W-1:0] weight_d;

  // round half away from zero on the extra quotient bit
  assign mag = ((QB+1)'(quo_q[QB]) + (QB+1)'(1)) >> 1;

  always_comb begin
    if (!neg_q[QB]) begin
      if (ovf_q[QB] || mag > MAG_POS) weight_d = OUT_W'(MAG_POS);
      else                            weight_d = OUT_W'(mag);
    end else begin
      if (ovf_q[QB] || mag > MAG_NEG) weight_d = OUT_W'(MAG_NEG);
      else                            weight_d = OUT_W'(-mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) weight_q <= weight_d;
  end

  assign weight_o = weight_q;

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for barycentric_point_in_triangle
// drives triangle/point beats, predicts weights in exact integer math, checks each result beat
// depends on bpit_pkg and the rtl of the block

`timescale 1ns / 100ps

module tb_top;
  import bpit_pkg::*;

  localparam int CW = 16;
  localparam int WF = 16;
  localparam int LATENCY = OUT_W + 9;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic             degen;
    logic             in_tri;
    logic [OUT_W-1:0] w;
    logic [OUT_W-1:0] v;
    logic [OUT_W-1:0] u;
  } weights_t;

  typedef struct {
    logic [CW-1:0] c[8];
    bit            typed;
    weights_t      want;
  } tri_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [8*CW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = CFG_TOLERANCE;
  logic [TOL_W-1:0] cfg_data_i = '0;

  barycentric_point_in_triangle #(.COORD_WIDTH(CW), .WEIGHT_FRAC(WF)) dut (.*);

  always #4 clk_i = ~clk_i;

  longint unsigned tol_q = 7, lim_q = 0;
  weights_t expected_weights[$];
  int errors = 0, beats_out = 0, beats_in = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off = 0;
  longint cycles = 0;

  function automatic longint sat_weight(longint x);
    longint hi = (longint'(1) << (OUT_W - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint rounded_ratio(longint num, longint den);
    longint unsigned n = num < 0 ? -num : num;
    longint unsigned d = den < 0 ? -den : den;
    longint unsigned cap = longint'(1) << 40;
    longint unsigned q = n / d, r = n % d;
    bit neg = (num < 0) != (den < 0);
    if (q > cap) q = cap;
    for (int i = 0; i < WF + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
      if (q > cap) q = cap;
    end
    q = (q + 1) >> 1;
    return sat_weight(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic weights_t barycentric(logic [CW-1:0] c[8]);
    longint s[8];
    longint e0x, e0y, e1x, e1y, e2x, e2y, den, nv, nw, nu, u, v, w, tol;
    longint unsigned dm;
    weights_t r;
    for (int i = 0; i < 8; i++) s[i] = longint'($signed(c[i]));
    e0x = s[2] - s[0]; e0y = s[3] - s[1];
    e1x = s[4] - s[0]; e1y = s[5] - s[1];
    e2x = s[6] - s[0]; e2y = s[7] - s[1];
    den = e0x * e1y - e0y * e1x;
    nv = e2x * e1y - e2y * e1x;
    nw = e0x * e2y - e0y * e2x;
    nu = den - nv - nw;
    dm = den < 0 ? -den : den;
    if (dm < (longint'(1) << 32) && dm * dm <= lim_q) begin
      r.u = OUT_W'(sat_weight(longint'(1) << WF));
      r.v = '0;
      r.w = '0;
      r.in_tri = 1'b0;
      r.degen = 1'b1;
    end else begin
      tol = -longint'(tol_q);
      u = rounded_ratio(nu, den);
      v = rounded_ratio(nv, den);
      w = rounded_ratio(nw, den);
      r.u = OUT_W'(u);
      r.v = OUT_W'(v);
      r.w = OUT_W'(w);
      r.in_tri = u >= tol && v >= tol && w >= tol;
      r.degen = 1'b0;
    end
    return r;
  endfunction

  // result side: stall and check
  always @(posedge clk_i) begin
    weights_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("Some tests failed");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[3*OUT_W+1:0];
      beats_out <= beats_out + 1;
      if (expected_weights.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = expected_weights.pop_front();
        if (got.u !== want.u || got.v !== want.v || got.w !== want.w ||
            got.in_tri !== want.in_tri || got.degen !== want.degen) begin
          $display("%0t: expected u=%h v=%h w=%h in=%b dg=%b got u=%h v=%h w=%h in=%b dg=%b",
                   $time, want.u, want.v, want.w, want.in_tri, want.degen,
                   got.u, got.v, got.w, got.in_tri, got.degen);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_triangle(logic [CW-1:0] c[8], bit typed, weights_t want);
    weights_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    for (int i = 0; i < 8; i++) s_axis_tdata[i*CW +: CW] <= c[i];
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = typed ? want : barycentric(c);
    expected_weights = {expected_weights, p};
    beats_in++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_weights.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [TOL_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TOLERANCE) tol_q = val;
    else lim_q = val;
    @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] rnd_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(256)) - 128);
      default: return CW'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  task automatic random_triangles(int n);
    logic [CW-1:0] c[8];
    weights_t none;
    int mode;
    none = '0;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(2);
      for (int i = 0; i < 8; i++) c[i] = rnd_coord(mode);
      case ($urandom_range(9))
        0: begin  // collinear
          c[4] = c[2]; c[5] = c[3];
        end
        1: begin  // point on a vertex
          c[6] = c[2]; c[7] = c[3];
        end
        2: begin  // tiny triangle
          c[2] = c[0] + CW'($urandom_range(2)); c[3] = c[1];
          c[4] = c[0]; c[5] = c[1] + CW'($urandom_range(2));
        end
        default: ;
      endcase
      send_triangle(c, 1'b0, none);
    end
  endtask

  tri_row_t directed[$];

  task automatic add_row(logic [CW-1:0] a0, a1, a2, a3, a4, a5, a6, a7,
                         bit typed, weights_t want);
    tri_row_t r;
    r.c[0] = a0; r.c[1] = a1; r.c[2] = a2; r.c[3] = a3;
    r.c[4] = a4; r.c[5] = a5; r.c[6] = a6; r.c[7] = a7;
    r.typed = typed;
    r.want = want;
    directed = {directed, r};
  endtask

  initial begin
    weights_t unit_u, unit_v, unit_w, degen_w, none;
    unit_u = '{u: 20'h10000, v: '0, w: '0, in_tri: 1'b1, degen: 1'b0};
    unit_v = '{u: '0, v: 20'h10000, w: '0, in_tri: 1'b1, degen: 1'b0};
    unit_w = '{u: '0, v: '0, w: 20'h10000, in_tri: 1'b1, degen: 1'b0};
    degen_w = '{u: 20'h10000, v: '0, w: '0, in_tri: 1'b0, degen: 1'b1};
    none = '0;
    // point on each vertex, degenerate, extremes, rounding, saturation
    add_row(0, 0, 16, 0, 0, 16, 0, 0, 1, unit_u);
    add_row(0, 0, 16, 0, 0, 16, 16, 0, 1, unit_v);
    add_row(0, 0, 16, 0, 0, 16, 0, 16, 1, unit_w);
    add_row(0, 0, 0, 0, 0, 0, 5, 9, 1, degen_w);
    add_row(0, 0, 16, 16, 32, 32, 1, 1, 1, degen_w);
    add_row(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
            16'h8000, 16'h8000, 0, none);
    add_row(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
            16'h7fff, 16'h7fff, 0, none);
    add_row(0, 0, 1, 0, 0, 1, 16'h7fff, 16'h7fff, 0, none);
    add_row(0, 0, 1, 0, 0, 1, 16'h8000, 16'h8000, 0, none);
    add_row(0, 0, 3, 0, 0, 3, 1, 1, 0, none);
    add_row(0, 0, 3, 0, 0, 3, 16'hffff, 2, 0, none);
    add_row(0, 0, 48, 0, 0, 48, 16, 16, 0, none);
    add_row(0, 0, 16, 0, 0, 16, 16'hffff, 0, 0, none);
    add_row(0, 0, 16, 0, 0, 16, 16'hfff8, 8, 0, none);
    add_row(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h1234, 16'hedcb, 16'h0f0f, 16'hf0f0,
            0, none);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_triangle(directed[i].c, directed[i].typed, directed[i].want);
    drain();

    // tolerance and degenerate limit sweeps with the extremes
    write_reg(CFG_TOLERANCE, 16'hffff);
    write_reg(CFG_DEG_LIMIT, 16'hffff);
    send_triangle(directed[0].c, 1'b0, none);
    random_triangles(150);
    drain();
    write_reg(CFG_TOLERANCE, 16'h0000);
    write_reg(CFG_DEG_LIMIT, 16'h0100);
    random_triangles(150);
    drain();

    // idling phases
    write_reg(CFG_TOLERANCE, 16'd7);
    write_reg(CFG_DEG_LIMIT, 16'd0);
    send_idle_pct = 69;
    random_triangles(350);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    random_triangles(350);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    random_triangles(350);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    hold_off = 300;
    random_triangles(200);
    drain();
    write_reg(CFG_TOLERANCE, 16'd1000);
    write_reg(CFG_DEG_LIMIT, 16'd40000);
    random_triangles(250);
    drain();

    $display("%0d triangle beats sent, %0d result beats checked, over five register settings",
             beats_in, beats_out);
    $display("covered vertices, degenerate limits, coordinate extremes and stalls on both sides");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
